/* rtl/max_heap_priority_queue_macros.svh */
// Assertion helpers for the heap queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define MHPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MHPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mhpq_pkg.sv */
package mhpq_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_RM_LOAD,
      S_DN_RD,
      S_DN_CMP,
      S_DONE
   } mhpq_state_type;

   typedef struct packed {
      logic accept;
      logic rd_parent;
      logic load_root;
      logic wr_cur;
      logic wr_move_up;
      logic wr_move_dn;
      logic publish;
   } mhpq_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic up_more;
      logic no_left;
      logic dn_more;
      logic rsp_busy;
   } mhpq_stat_type;

endpackage

/* rtl/max_heap_priority_queue.sv */
// channel  | handshake            | word
// ---------+----------------------+---------------------------------------------
// req      | req_valid/req_ready  | req_func, req_new_value
// rsp      | rsp_valid/rsp_ready  | rsp_removed_value, rsp_status, rsp_count_after
//
// One item at a time. Each heap level takes a registered RAM read of the
// parent (insert) or both children (remove), then a compare and write; a sift
// walks at most log2(DEPTH) levels. Refused/empty go straight to the final step.
// Synchronous reset clears the count and the result valid; RAM contents are kept.
// A stalled result holds only the final step; the sift itself never waits.
module max_heap_priority_queue #(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_new_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_removed_value,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_count_after
);
   import mhpq_pkg::*;

   mhpq_cmd_type  cmd;
   mhpq_stat_type stat;

   mhpq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_func (req_func),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   mhpq_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_new_value    (req_new_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_removed_value(rsp_removed_value),
      .rsp_status       (rsp_status),
      .rsp_count_after  (rsp_count_after)
   );

endmodule

/* rtl/mhpq_ram.sv */
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata0,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
   end

endmodule

/* rtl/mhpq_ctrl.sv */
module mhpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   output logic                   req_ready,
   input  mhpq_pkg::mhpq_stat_type stat,
   output mhpq_pkg::mhpq_cmd_type  cmd
);
   import mhpq_pkg::*;

   mhpq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == OP_INSERT) begin
                  state_in = stat.full ? S_DONE : S_UP_RD;
               end else begin
                  state_in = stat.empty ? S_DONE : S_RM_LOAD;
               end
            end
         end
         S_UP_RD:   state_in = stat.pos_zero ? S_DONE : S_UP_CMP;
         S_UP_CMP:  state_in = stat.up_more ? S_UP_RD : S_DONE;
         S_RM_LOAD: state_in = S_DN_RD;
         S_DN_RD:   state_in = stat.no_left ? S_DONE : S_DN_CMP;
         S_DN_CMP:  state_in = stat.dn_more ? S_DN_RD : S_DONE;
         S_DONE:    state_in = stat.rsp_busy ? S_DONE : S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_UP_RD: begin
            cmd.wr_cur    = stat.pos_zero;
            cmd.rd_parent = !stat.pos_zero;
         end
         S_UP_CMP: begin
            cmd.wr_move_up = stat.up_more;
            cmd.wr_cur     = !stat.up_more;
         end
         S_RM_LOAD: cmd.load_root = 1'b1;
         // a leaf keeps the moving word
         S_DN_RD:   cmd.wr_cur = stat.no_left;
         S_DN_CMP: begin
            cmd.wr_move_dn = stat.dn_more;
            cmd.wr_cur     = !stat.dn_more;
         end
         S_DONE:    cmd.publish = !stat.rsp_busy;
         default:   cmd = '0;
      endcase
   end

endmodule

/* rtl/mhpq_dp.sv */
`include "max_heap_priority_queue_macros.svh"

module mhpq_dp #(
   parameter int DEPTH = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mhpq_pkg::mhpq_cmd_type  cmd,
   output mhpq_pkg::mhpq_stat_type stat,
   input  logic                    req_func,
   input  logic [31:0]             req_new_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [31:0]             rsp_removed_value,
   output logic [1:0]              rsp_status,
   output logic [7:0]              rsp_count_after
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic signed [31:0]  cur_ff, cur_in;
   logic signed [31:0]  rem_ff, rem_in;
   logic [1:0]          st_ff, st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_count_ff, rsp_count_in;

   logic [AW-1:0]       parent;
   logic [AW:0]         left;
   logic [AW+1:0]       right;
   logic [AW+1:0]       count_x;
   logic signed [31:0]  rdata0, rdata1, big_val, wdata;
   logic [AW-1:0]       big_pos, raddr0, raddr1;
   logic                right_wins, we;
   logic [31:0]         count_wide;

   assign parent  = (pos_ff - AW'(1)) >> 1;
   assign left    = {pos_ff, 1'b1};
   assign right   = {1'b0, left} + (AW+2)'(1);
   assign count_x = (AW+2)'(count_ff);

   assign right_wins = (right < count_x) && (rdata1 > rdata0);
   assign big_val    = right_wins ? rdata1 : rdata0;
   assign big_pos    = right_wins ? right[AW-1:0] : left[AW-1:0];

   // root and last are fetched in the accept cycle
   assign raddr0 = cmd.accept ? '0 : (cmd.rd_parent ? parent : left[AW-1:0]);
   assign raddr1 = cmd.accept ? AW'(count_ff - CW'(1)) : right[AW-1:0];

   assign we    = cmd.wr_cur | cmd.wr_move_up | cmd.wr_move_dn;
   assign wdata = cmd.wr_move_up ? rdata0 : (cmd.wr_move_dn ? big_val : cur_ff);

   mhpq_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (pos_ff),
      .wdata (wdata),
      .raddr0(raddr0),
      .raddr1(raddr1),
      .rdata0(rdata0),
      .rdata1(rdata1)
   );

   always_comb begin
      stat.full     = (count_ff == CW'(DEPTH));
      stat.empty    = (count_ff == '0);
      stat.pos_zero = (pos_ff == '0);
      stat.up_more  = (cur_ff > rdata0);
      stat.no_left  = ({1'b0, left} >= count_x);
      stat.dn_more  = (big_val > cur_ff);
      stat.rsp_busy = rsp_valid_ff & ~rsp_ready;
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      st_in    = st_ff;
      if (cmd.accept) begin
         rem_in = '0;
         st_in  = ST_OK;
         if (req_func == OP_INSERT) begin
            if (stat.full) begin
               st_in = ST_FULL;
            end else begin
               pos_in   = AW'(count_ff);
               cur_in   = req_new_value;
               count_in = count_ff + CW'(1);
            end
         end else if (stat.empty) begin
            st_in = ST_EMPTY;
         end
      end
      if (cmd.load_root) begin
         rem_in   = rdata0;
         cur_in   = rdata1;
         pos_in   = '0;
         count_in = count_ff - CW'(1);
      end
      if (cmd.wr_move_up) begin
         pos_in = parent;
      end
      if (cmd.wr_move_dn) begin
         pos_in = big_pos;
      end
   end

   assign count_wide = 32'(count_ff);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.publish) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = rem_ff;
         rsp_status_in = st_ff;
         rsp_count_in  = count_wide[7:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      rem_ff        <= rem_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_count_after   = rsp_count_ff;

   `MHPQ_ASSERT_NEXT(a_full_keeps_count, clock, reset,
      cmd.accept && req_func == OP_INSERT && stat.full, $stable(count_ff),
      "refused insert changed the count")
   `MHPQ_ASSERT_NOW(a_publish_slot_free, clock, reset,
      cmd.publish, !(rsp_valid_ff && !rsp_ready), "result word overwritten")
   `MHPQ_ASSERT_NEXT(a_remove_decrements, clock, reset,
      cmd.load_root, count_ff == CW'($past(count_ff) - CW'(1)),
      "remove did not decrement the count")

endmodule
